### sv/gip_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gip_pkg - gradient palette shared definitions
// Default widths, the five gradient stops and their colors.
// ---------------------------------------------------------------------------
package gip_pkg;

    localparam int COUNT_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int MAX_ITER_RESET    = 256;
    localparam int CFG_BITS          = 16;
    localparam int CHAN_BITS         = 8;
    localparam int NUM_CHAN          = 3;
    localparam int STOP_CNT          = 5;
    localparam int NUM_SEGS          = STOP_CNT - 1;

    // color word, red in the lowest byte
    typedef logic [NUM_CHAN-1:0][CHAN_BITS-1:0] t_rgb;

    // stop positions in units of 1/10000
    localparam int STOP_POS_E4 [STOP_CNT] = '{0, 1600, 4200, 6425, 8575};

    localparam t_rgb STOP_RGB [STOP_CNT] = '{
        {8'd100, 8'd7,   8'd0  },
        {8'd203, 8'd107, 8'd32 },
        {8'd255, 8'd255, 8'd237},
        {8'd0,   8'd170, 8'd255},
        {8'd0,   8'd2,   8'd0  }
    };

    // stop position as a fraction with fbits fraction bits, rounded to nearest
    function automatic longint stop_q(int k, int fbits);
        return ((longint'(STOP_POS_E4[k]) << fbits) + 64'sd5000) / 64'sd10000;
    endfunction

endpackage

### sv/gip_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gip_div - pipelined restoring divider
// One quotient bit per stage, LANES numerators over one shared divisor.
// Numerator must be below divisor * 2^QW.
// ---------------------------------------------------------------------------
module gip_div #(
    parameter int DW    = 16,
    parameter int QW    = 16,
    parameter int LANES = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic [LANES-1:0][DW+QW-1:0]      i_num,
    input  logic [DW-1:0]                    i_den,
    output logic                             o_vld,
    output logic [LANES-1:0][QW-1:0]         o_quo
);

    localparam int NW = DW + QW;

    logic                        r_vld [1:QW];
    logic [LANES-1:0][NW-1:0]    r_rem [1:QW];
    logic [LANES-1:0][QW-1:0]    r_quo [1:QW];
    logic [DW-1:0]               r_den [1:QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int K = QW - 1 - s;

        logic                     w_vld_in;
        logic [LANES-1:0][NW-1:0] w_rem_in;
        logic [LANES-1:0][QW-1:0] w_quo_in;
        logic [DW-1:0]            w_den_in;
        logic [NW-1:0]            w_sub;
        logic [LANES-1:0][NW-1:0] n_rem;
        logic [LANES-1:0][QW-1:0] n_quo;

        if (s == 0) begin : g_first
            assign w_vld_in = i_vld;
            assign w_rem_in = i_num;
            assign w_quo_in = '0;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_vld_in = r_vld[s];
            assign w_rem_in = r_rem[s];
            assign w_quo_in = r_quo[s];
            assign w_den_in = r_den[s];
        end

        assign w_sub = NW'(w_den_in) << K;

        always_comb begin
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            for (int l = 0; l < LANES; l++) begin
                if (w_rem_in[l] >= w_sub) begin
                    n_rem[l]    = w_rem_in[l] - w_sub;
                    n_quo[l][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_quo[s+1] <= n_quo;
                r_den[s+1] <= w_den_in;
            end
        end
    end

    assign o_vld = r_vld[QW];
    assign o_quo = r_quo[QW];

endmodule

### sv/gip_interp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gip_interp - segment select and interpolation numerators
// Three stages: segment and offset, channel products, channel sums.
// ---------------------------------------------------------------------------
module gip_interp #(
    parameter int FRACTION_BITS = gip_pkg::FRACTION_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_vld,
    input  logic [FRACTION_BITS-1:0]                      i_pos,
    output logic                                          o_vld,
    output logic [gip_pkg::NUM_CHAN-1:0][FRACTION_BITS+gip_pkg::CHAN_BITS-1:0] o_num,
    output logic [FRACTION_BITS-1:0]                      o_den
);

    localparam int F  = FRACTION_BITS;
    localparam int PW = F + gip_pkg::CHAN_BITS;
    localparam int NC = gip_pkg::NUM_CHAN;

    localparam logic [F-1:0] S0 = F'(gip_pkg::stop_q(0, F));
    localparam logic [F-1:0] S1 = F'(gip_pkg::stop_q(1, F));
    localparam logic [F-1:0] S2 = F'(gip_pkg::stop_q(2, F));
    localparam logic [F-1:0] S3 = F'(gip_pkg::stop_q(3, F));
    localparam logic [F-1:0] S4 = F'(gip_pkg::stop_q(4, F));

    // stage 1: segment, offset into it and remaining distance
    logic [1:0]   n_seg;
    logic [F-1:0] n_lo;
    logic [F-1:0] n_den;
    logic [F-1:0] n_off;

    logic         r1_vld;
    logic [1:0]   r1_seg;
    logic [F-1:0] r1_off;
    logic [F-1:0] r1_rest;
    logic [F-1:0] r1_den;

    always_comb begin
        if (i_pos >= S3) begin
            n_seg = 2'd3;
        end else if (i_pos >= S2) begin
            n_seg = 2'd2;
        end else if (i_pos >= S1) begin
            n_seg = 2'd1;
        end else begin
            n_seg = 2'd0;
        end
        case (n_seg)
            2'd0:    begin n_lo = S0; n_den = S1 - S0; end
            2'd1:    begin n_lo = S1; n_den = S2 - S1; end
            2'd2:    begin n_lo = S2; n_den = S3 - S2; end
            default: begin n_lo = S3; n_den = S4 - S3; end
        endcase
        // clamp at the last stop so the far end yields the last colour
        if (i_pos >= S4) begin
            n_off = n_den;
        end else begin
            n_off = i_pos - n_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_seg  <= n_seg;
            r1_off  <= n_off;
            r1_rest <= n_den - n_off;
            r1_den  <= n_den;
        end
    end

    // stage 2: weighted stop colours
    gip_pkg::t_rgb w_c_lo;
    gip_pkg::t_rgb w_c_hi;

    logic                  r2_vld;
    logic [NC-1:0][PW-1:0] r2_pa;
    logic [NC-1:0][PW-1:0] r2_pb;
    logic [F-1:0]          r2_den;

    assign w_c_lo = gip_pkg::STOP_RGB[{1'b0, r1_seg}];
    assign w_c_hi = gip_pkg::STOP_RGB[3'({1'b0, r1_seg}) + 3'd1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < NC; c++) begin
                r2_pa[c] <= PW'(w_c_lo[c]) * PW'(r1_rest);
                r2_pb[c] <= PW'(w_c_hi[c]) * PW'(r1_off);
            end
            r2_den <= r1_den;
        end
    end

    // stage 3: numerators, at most 255 * den so they fit PW bits
    logic                  r3_vld;
    logic [NC-1:0][PW-1:0] r3_num;
    logic [F-1:0]          r3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < NC; c++) begin
                r3_num[c] <= r2_pa[c] + r2_pb[c];
            end
            r3_den <= r2_den;
        end
    end

    assign o_vld = r3_vld;
    assign o_num = r3_num;
    assign o_den = r3_den;

endmodule

### sv/gradient_iteration_palette.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gradient_iteration_palette - iteration count to gradient color
// Maps an escape-iteration count to RGB over five fixed gradient stops.
// ---------------------------------------------------------------------------
// Takes one iteration count per cycle and returns one 24-bit color per count,
// in order. The count is divided by the iteration cap into a position with
// FRACTION_BITS fraction bits (rounded down, counts at or above the cap and a
// cap of zero give the last color), the bracketing pair of stops is found and
// each channel is the exact linear blend of the two stop colors, truncated.
// The pipeline is one input stage, a FRACTION_BITS-stage position divider at one
// quotient bit per stage, three interpolation stages and an 8-stage channel
// divider whose last stage is the output register. Throughput is one item per
// cycle; the whole pipeline holds while the output item waits, so s_axis_tready
// follows m_axis_tready whenever the output register is full. The iteration cap
// is to be written through the cfg port only while the pipeline is empty; the
// block does not enforce this. It resets to 256; only its low COUNT_BITS bits
// are kept, and likewise for the count.
// ---------------------------------------------------------------------------
module gradient_iteration_palette #(
    parameter int COUNT_BITS    = gip_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = gip_pkg::FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: iteration cap
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // iteration_count[15:0]
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int C  = COUNT_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int NW = C + F;
    localparam int CW = gip_pkg::CHAN_BITS;
    localparam int NC = gip_pkg::NUM_CHAN;

    // pipeline advance: output register empty or being drained
    logic w_en;

    // cap register
    logic [C-1:0] r_max_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= C'(gip_pkg::MAX_ITER_RESET);
        end else if (i_cfg_wr_en) begin
            r_max_iter <= C'(i_cfg_wr_data);
        end
    end

    // input stage: division operands; saturated counts become a quotient of
    // all ones, which lies past the last stop
    logic [C-1:0]  w_count;
    logic          w_sat;
    logic          r_in_vld;
    logic [NW-1:0] r_num;
    logic [C-1:0]  r_den;

    assign w_count = C'(i_s_axis_tdata);
    assign w_sat   = (w_count >= r_max_iter);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_sat) begin
                r_num <= NW'({F{1'b1}});
                r_den <= C'(1);
            end else begin
                r_num <= {w_count, {F{1'b0}}};
                r_den <= r_max_iter;
            end
        end
    end

    // position divider: count * 2^F / max, F quotient bits
    logic                w_pos_vld;
    logic [0:0][F-1:0]   w_pos;

    gip_div #(
        .DW    (C),
        .QW    (F),
        .LANES (1)
    ) u_pos_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_in_vld),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_vld   (w_pos_vld),
        .o_quo   (w_pos)
    );

    // segment select and blend numerators
    logic                      w_mix_vld;
    logic [NC-1:0][F+CW-1:0]   w_mix_num;
    logic [F-1:0]              w_mix_den;

    gip_interp #(
        .FRACTION_BITS (F)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_pos_vld),
        .i_pos   (w_pos[0]),
        .o_vld   (w_mix_vld),
        .o_num   (w_mix_num),
        .o_den   (w_mix_den)
    );

    // channel divider: blend / segment length, 8 quotient bits per channel
    logic                  w_out_vld;
    logic [NC-1:0][CW-1:0] w_rgb;

    gip_div #(
        .DW    (F),
        .QW    (CW),
        .LANES (NC)
    ) u_chan_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_mix_vld),
        .i_num   (w_mix_num),
        .i_den   (w_mix_den),
        .o_vld   (w_out_vld),
        .o_quo   (w_rgb)
    );

    assign w_en            = !w_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = w_out_vld;
    assign o_m_axis_tdata  = w_rgb;

endmodule
